// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// shared types, codes and constants of the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int TIMERS = 32;
   localparam int QUEUES = 16;
   localparam int SLOT_W = $clog2(TIMERS);

   localparam logic [31:0] SENTINEL_DL = 32'hFFFF_FFFF;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [2:0] OP_ALLOC      = 3'd0;
   localparam logic [2:0] OP_FREE       = 3'd1;
   localparam logic [2:0] OP_BIND       = 3'd2;
   localparam logic [2:0] OP_ARM        = 3'd3;
   localparam logic [2:0] OP_TICK       = 3'd4;
   localparam logic [2:0] OP_CANCEL     = 3'd5;
   localparam logic [2:0] OP_CANCEL_ALL = 3'd6;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       deadline;
      logic [SLOT_W-1:0] nxt;
      logic [3:0]        queue;
      logic [31:0]       msg;
      logic              cflag;
   } rec_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      rec_type           wrec;
      logic              re;
      logic [SLOT_W-1:0] raddr;
   } mem_req_type;

   function automatic rec_type reset_rec(input logic [SLOT_W-1:0] idx);
      rec_type r;
      r = '0;
      if (idx == '0) begin
         r.status   = ST_RUN;
         r.deadline = SENTINEL_DL;
      end
      return r;
   endfunction

endpackage

// ===== src/stq_store.sv =====
// ----------------------------------------------------------------------------
// stq_store
// timer record memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stq_store (
   input  logic                clock,
   input  logic                reset,
   input  stq_pkg::mem_req_type mreq,
   output stq_pkg::rec_type    rd_rec
);

   stq_pkg::rec_type                   mem_ff [stq_pkg::TIMERS];
   stq_pkg::rec_type                   rdq_ff;
   logic [stq_pkg::TIMERS-1:0]         valid_ff;
   logic                               rdv_ff;
   logic [stq_pkg::SLOT_W-1:0]         rda_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem_ff[mreq.waddr] <= mreq.wrec;
      end
      if (mreq.re) begin
         rdq_ff <= mem_ff[mreq.raddr];
         rda_ff <= mreq.raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         if (mreq.re) begin
            rdv_ff <= valid_ff[mreq.raddr];
         end
         if (mreq.we) begin
            valid_ff[mreq.waddr] <= 1'b1;
         end
      end
   end

   assign rd_rec = rdv_ff ? rdq_ff : stq_pkg::reset_rec(rda_ff);

endmodule

// ===== src/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// pool of timers kept as a deadline-sorted linked list in a record memory
// ----------------------------------------------------------------------------
// usage: one request at a time enters on req_*, operation code in req_tuser.
// each command gives one reply (kind 0); a tick gives one expiry message per
// expired timer other than the task timer, in deadline order, then a tick end
// carrying the switch flag. rsp_tlast marks the final result of a request.
// alloc and cancel all scan slots 1..31, one per cycle; cancel all also walks
// the list for each running timer that it removes. arm, cancel and free walk
// the list, one node per cycle. a tick that finds nothing expired goes straight
// to the tick end, else it walks the expired timers from the head. the record
// memory does one read and one write a cycle, with a registered read.
// req_tready is high only between requests.
// reset: synchronous; the list holds only the sentinel in slot 0, tick count
// zero, task timer none. memory entries read as their reset value until
// first written, through per-entry valid bits, so no clearing pass is needed.
// stall: results sit in one output register; the walk pauses while it is full.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // slot, queue_id, message, delay, auto_cancel
   input  logic [2:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // slot_out, ok, dest_queue, payload, switch_flag
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   localparam int SW = stq_pkg::SLOT_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(stq_pkg::TIMERS - 1);
   localparam logic [SW-1:0] FIRST_SLOT = SW'(1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_A_CHK  = 4'd1;
   localparam logic [3:0] S_S_CHK  = 4'd2;
   localparam logic [3:0] S_U_CHK  = 4'd3;
   localparam logic [3:0] S_U_HD   = 4'd4;
   localparam logic [3:0] S_U_WR   = 4'd5;
   localparam logic [3:0] S_I_PCHK = 4'd6;
   localparam logic [3:0] S_I_TCHK = 4'd7;
   localparam logic [3:0] S_I_W2   = 4'd8;
   localparam logic [3:0] S_T_CHK  = 4'd9;
   localparam logic [3:0] S_T_END  = 4'd10;
   localparam logic [3:0] S_C_CHK  = 4'd11;
   localparam logic [3:0] S_REPLY  = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [5:0]        tts_ff;
   logic [31:0]       tick_ff, tick_in;
   logic [31:0]       earliest_ff, earliest_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [2:0]        op_ff, op_in;
   logic [SW-1:0]     s_ff, s_in;
   logic [3:0]        q_ff, q_in;
   logic [31:0]       msg_ff, msg_in;
   logic [31:0]       dly_ff, dly_in;
   logic              ac_ff, ac_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic [SW-1:0]     wk_ff, wk_in;
   logic [SW-1:0]     t_ff, t_in;
   logic [SW-1:0]     u_ff, u_in;
   logic [1:0]        fin_ff, fin_in;
   logic              ok_ff, ok_in;
   logic [SW-1:0]     sout_ff, sout_in;
   logic              ts_ff, ts_in;
   logic              any_ff, any_in;
   stq_pkg::rec_type  srec_ff, srec_in;
   stq_pkg::rec_type  prev_ff, prev_in;

   logic              out_v_ff, out_v_in;
   logic [1:0]        out_kind_ff, out_kind_in;
   logic [SW-1:0]     out_slot_ff, out_slot_in;
   logic              out_ok_ff, out_ok_in;
   logic [3:0]        out_q_ff, out_q_in;
   logic [31:0]       out_pay_ff, out_pay_in;
   logic              out_ts_ff, out_ts_in;
   logic              out_last_ff, out_last_in;

   stq_pkg::mem_req_type mreq;
   stq_pkg::rec_type     rdat;
   stq_pkg::rec_type     wtmp;
   logic                 can_emit;
   logic                 match;
   logic [31:0]          dl;

   stq_store u_store (
      .clock  (clock),
      .reset  (reset),
      .mreq   (mreq),
      .rd_rec (rdat)
   );

   assign can_emit   = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign dl         = dly_ff + tick_ff;
   assign match      = (rdat.status != stq_pkg::ST_FREE) && rdat.cflag && (rdat.queue == q_ff);

   always_comb begin
      state_in    = state_ff;
      tick_in     = tick_ff;
      earliest_in = earliest_ff;
      head_in     = head_ff;
      op_in       = op_ff;
      s_in        = s_ff;
      q_in        = q_ff;
      msg_in      = msg_ff;
      dly_in      = dly_ff;
      ac_in       = ac_ff;
      cur_in      = cur_ff;
      wk_in       = wk_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      fin_in      = fin_ff;
      ok_in       = ok_ff;
      sout_in     = sout_ff;
      ts_in       = ts_ff;
      any_in      = any_ff;
      srec_in     = srec_ff;
      prev_in     = prev_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_slot_in = out_slot_ff;
      out_ok_in   = out_ok_ff;
      out_q_in    = out_q_ff;
      out_pay_in  = out_pay_ff;
      out_ts_in   = out_ts_ff;
      out_last_in = out_last_ff;
      mreq        = '0;
      wtmp        = rdat;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               s_in    = req_tdata[4:0];
               q_in    = req_tdata[8:5];
               msg_in  = req_tdata[40:9];
               dly_in  = req_tdata[72:41];
               ac_in   = req_tdata[73];
               ok_in   = 1'b0;
               sout_in = '0;
               ts_in   = 1'b0;
               any_in  = 1'b0;
               priority case (req_tuser)
                  stq_pkg::OP_ALLOC, stq_pkg::OP_CANCEL_ALL: begin
                     cur_in     = FIRST_SLOT;
                     mreq.re    = 1'b1;
                     mreq.raddr = FIRST_SLOT;
                     state_in   = (req_tuser == stq_pkg::OP_ALLOC) ? S_A_CHK : S_C_CHK;
                  end
                  stq_pkg::OP_FREE, stq_pkg::OP_BIND, stq_pkg::OP_ARM,
                  stq_pkg::OP_CANCEL: begin
                     if (req_tdata[4:0] != '0) begin
                        mreq.re    = 1'b1;
                        mreq.raddr = req_tdata[4:0];
                        state_in   = S_S_CHK;
                     end else begin
                        state_in = S_REPLY;
                     end
                  end
                  stq_pkg::OP_TICK: begin
                     tick_in = tick_ff + 32'd1;
                     if (earliest_ff <= tick_ff + 32'd1) begin
                        wk_in      = head_ff;
                        mreq.re    = 1'b1;
                        mreq.raddr = head_ff;
                        state_in   = S_T_CHK;
                     end else begin
                        state_in = S_T_END;
                     end
                  end
                  default: state_in = S_REPLY;
               endcase
            end
         end

         S_A_CHK: begin
            if (rdat.status == stq_pkg::ST_FREE) begin
               wtmp.status = stq_pkg::ST_ALLOC;
               wtmp.cflag  = 1'b0;
               mreq.we     = 1'b1;
               mreq.waddr  = cur_ff;
               mreq.wrec   = wtmp;
               ok_in       = 1'b1;
               sout_in     = cur_ff;
               state_in    = S_REPLY;
            end else if (cur_ff == LAST_SLOT) begin
               state_in = S_REPLY;
            end else begin
               cur_in     = cur_ff + FIRST_SLOT;
               mreq.re    = 1'b1;
               mreq.raddr = cur_ff + FIRST_SLOT;
            end
         end

         S_S_CHK: begin
            unique case (op_ff)
               stq_pkg::OP_BIND: begin
                  if (int'(q_ff) < stq_pkg::QUEUES) begin
                     wtmp.queue = q_ff;
                     wtmp.msg   = msg_ff;
                     wtmp.cflag = ac_ff;
                     mreq.we    = 1'b1;
                     mreq.waddr = s_ff;
                     mreq.wrec  = wtmp;
                     ok_in      = 1'b1;
                  end
                  state_in = S_REPLY;
               end
               stq_pkg::OP_ARM: begin
                  if (rdat.status == stq_pkg::ST_ALLOC) begin
                     wtmp.status   = stq_pkg::ST_RUN;
                     wtmp.deadline = dl;
                     ok_in         = 1'b1;
                     if (dl <= earliest_ff) begin
                        wtmp.nxt    = head_ff;
                        head_in     = s_ff;
                        earliest_in = dl;
                        mreq.we     = 1'b1;
                        mreq.waddr  = s_ff;
                        mreq.wrec   = wtmp;
                        state_in    = S_REPLY;
                     end else begin
                        srec_in    = wtmp;
                        wk_in      = head_ff;
                        mreq.re    = 1'b1;
                        mreq.raddr = head_ff;
                        state_in   = S_I_PCHK;
                     end
                  end else begin
                     state_in = S_REPLY;
                  end
               end
               default: begin
                  if (rdat.status == stq_pkg::ST_RUN) begin
                     u_in    = s_ff;
                     srec_in = rdat;
                     fin_in  = (op_ff == stq_pkg::OP_FREE) ? stq_pkg::ST_FREE
                                                            : stq_pkg::ST_ALLOC;
                     mreq.re = 1'b1;
                     if (s_ff == head_ff) begin
                        head_in    = rdat.nxt;
                        mreq.raddr = rdat.nxt;
                        state_in   = S_U_HD;
                     end else begin
                        wk_in      = head_ff;
                        mreq.raddr = head_ff;
                        state_in   = S_U_CHK;
                     end
                  end else begin
                     if (op_ff == stq_pkg::OP_FREE) begin
                        wtmp.status = stq_pkg::ST_FREE;
                        mreq.we     = 1'b1;
                        mreq.waddr  = s_ff;
                        mreq.wrec   = wtmp;
                        ok_in       = 1'b1;
                     end
                     state_in = S_REPLY;
                  end
               end
            endcase
         end

         S_U_CHK: begin
            if (rdat.nxt == u_ff) begin
               wtmp.nxt   = srec_ff.nxt;
               mreq.we    = 1'b1;
               mreq.waddr = wk_ff;
               mreq.wrec  = wtmp;
               state_in   = S_U_WR;
            end else if (wk_ff == '0) begin
               state_in = S_U_WR;
            end else begin
               wk_in      = rdat.nxt;
               mreq.re    = 1'b1;
               mreq.raddr = rdat.nxt;
            end
         end

         S_U_HD: begin
            earliest_in = rdat.deadline;
            state_in    = S_U_WR;
         end

         S_U_WR: begin
            wtmp        = srec_ff;
            wtmp.status = fin_ff;
            mreq.we     = 1'b1;
            mreq.waddr  = u_ff;
            mreq.wrec   = wtmp;
            ok_in       = 1'b1;
            if (op_ff == stq_pkg::OP_CANCEL_ALL && cur_ff != LAST_SLOT) begin
               cur_in     = cur_ff + FIRST_SLOT;
               mreq.re    = 1'b1;
               mreq.raddr = cur_ff + FIRST_SLOT;
               state_in   = S_C_CHK;
            end else begin
               state_in = S_REPLY;
            end
         end

         S_I_PCHK: begin
            prev_in    = rdat;
            t_in       = rdat.nxt;
            mreq.re    = 1'b1;
            mreq.raddr = rdat.nxt;
            state_in   = S_I_TCHK;
         end

         S_I_TCHK: begin
            if (t_ff == '0 || srec_ff.deadline <= rdat.deadline) begin
               wtmp       = prev_ff;
               wtmp.nxt   = s_ff;
               mreq.we    = 1'b1;
               mreq.waddr = wk_ff;
               mreq.wrec  = wtmp;
               srec_in.nxt = t_ff;
               state_in   = S_I_W2;
            end else begin
               wk_in      = t_ff;
               prev_in    = rdat;
               t_in       = rdat.nxt;
               mreq.re    = 1'b1;
               mreq.raddr = rdat.nxt;
            end
         end

         S_I_W2: begin
            mreq.we    = 1'b1;
            mreq.waddr = s_ff;
            mreq.wrec  = srec_ff;
            state_in   = S_REPLY;
         end

         S_T_CHK: begin
            if (wk_ff == '0 || rdat.deadline > tick_ff) begin
               head_in     = wk_ff;
               earliest_in = rdat.deadline;
               state_in    = S_T_END;
            end else if (6'(wk_ff) == tts_ff || can_emit) begin
               wtmp.status = stq_pkg::ST_ALLOC;
               mreq.we     = 1'b1;
               mreq.waddr  = wk_ff;
               mreq.wrec   = wtmp;
               wk_in       = rdat.nxt;
               mreq.re     = 1'b1;
               mreq.raddr  = rdat.nxt;
               if (6'(wk_ff) == tts_ff) begin
                  ts_in = 1'b1;
               end else begin
                  out_v_in    = 1'b1;
                  out_kind_in = stq_pkg::KIND_EXPIRY;
                  out_slot_in = wk_ff;
                  out_ok_in   = 1'b0;
                  out_q_in    = rdat.queue;
                  out_pay_in  = rdat.msg;
                  out_ts_in   = 1'b0;
                  out_last_in = 1'b0;
               end
            end
         end

         S_T_END: begin
            if (can_emit) begin
               out_v_in    = 1'b1;
               out_kind_in = stq_pkg::KIND_END;
               out_slot_in = '0;
               out_ok_in   = 1'b0;
               out_q_in    = '0;
               out_pay_in  = '0;
               out_ts_in   = ts_ff;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end

         S_C_CHK: begin
            if (match) begin
               any_in = 1'b1;
            end
            if (match && rdat.status == stq_pkg::ST_RUN) begin
               u_in    = cur_ff;
               srec_in = rdat;
               fin_in  = stq_pkg::ST_FREE;
               mreq.re = 1'b1;
               if (cur_ff == head_ff) begin
                  head_in    = rdat.nxt;
                  mreq.raddr = rdat.nxt;
                  state_in   = S_U_HD;
               end else begin
                  wk_in      = head_ff;
                  mreq.raddr = head_ff;
                  state_in   = S_U_CHK;
               end
            end else begin
               if (match) begin
                  wtmp.status = stq_pkg::ST_FREE;
                  mreq.we     = 1'b1;
                  mreq.waddr  = cur_ff;
                  mreq.wrec   = wtmp;
               end
               if (cur_ff == LAST_SLOT) begin
                  ok_in    = any_ff || match;
                  state_in = S_REPLY;
               end else begin
                  cur_in     = cur_ff + FIRST_SLOT;
                  mreq.re    = 1'b1;
                  mreq.raddr = cur_ff + FIRST_SLOT;
               end
            end
         end

         S_REPLY: begin
            if (can_emit) begin
               out_v_in    = 1'b1;
               out_kind_in = stq_pkg::KIND_REPLY;
               out_slot_in = sout_ff;
               out_ok_in   = ok_ff;
               out_q_in    = '0;
               out_pay_in  = '0;
               out_ts_in   = 1'b0;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tts_ff      <= 6'd32;
         tick_ff     <= '0;
         earliest_ff <= stq_pkg::SENTINEL_DL;
         head_ff     <= '0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         if (csr_wr_en) begin
            tts_ff <= csr_wr_data;
         end
         tick_ff     <= tick_in;
         earliest_ff <= earliest_in;
         head_ff     <= head_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      s_ff        <= s_in;
      q_ff        <= q_in;
      msg_ff      <= msg_in;
      dly_ff      <= dly_in;
      ac_ff       <= ac_in;
      cur_ff      <= cur_in;
      wk_ff       <= wk_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      fin_ff      <= fin_in;
      ok_ff       <= ok_in;
      sout_ff     <= sout_in;
      ts_ff       <= ts_in;
      any_ff      <= any_in;
      srec_ff     <= srec_in;
      prev_ff     <= prev_in;
      out_kind_ff <= out_kind_in;
      out_slot_ff <= out_slot_in;
      out_ok_ff   <= out_ok_in;
      out_q_ff    <= out_q_in;
      out_pay_ff  <= out_pay_in;
      out_ts_ff   <= out_ts_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'd0, out_ts_ff, out_pay_ff, out_q_ff, out_ok_ff, out_slot_ff};

   // empty list means the sentinel deadline is the earliest one
   a_head_sentinel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && head_ff == '0) |-> earliest_ff == stq_pkg::SENTINEL_DL)
      else $error("earliest deadline out of step with empty list");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mreq.we && mreq.re) |-> mreq.waddr != mreq.raddr)
      else $error("record read and write hit the same entry");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff != S_IDLE)
      else $error("request accepted without work started");

endmodule
